[src/tcp_pkg.sv]
// shared types, constants and helpers of the tile constraint propagator
`timescale 1ns / 1ps
package tcp_pkg;

   localparam int MAX_DIM      = 8;
   localparam int MAX_PATTERNS = 16;
   localparam int DIRECTIONS   = 6;
   localparam int COORD_W      = $clog2(MAX_DIM);
   localparam int CELL_COUNT   = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int CELL_AW      = $clog2(CELL_COUNT);
   localparam int QLEN_W       = CELL_AW + 1;
   localparam int DOM_W        = MAX_PATTERNS;
   localparam int CELL_W       = DOM_W + 2;
   localparam int QUEUED_BIT   = DOM_W;
   localparam int CHANGED_BIT  = DOM_W + 1;
   localparam int PAT_W        = $clog2(MAX_PATTERNS);
   localparam int NP_W         = PAT_W + 1;
   localparam int DIR_W        = 3;
   localparam int EXT_W        = 4;
   localparam int COMPAT_DEPTH = DIRECTIONS * MAX_PATTERNS;
   localparam int COMPAT_AW    = DIR_W + PAT_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 5;

   localparam logic signed [1:0] STEP_X [DIRECTIONS] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0};
   localparam logic signed [1:0] STEP_Y [DIRECTIONS] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] STEP_Z [DIRECTIONS] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1};

   typedef enum logic [1:0] {
      CMD_COMPAT = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_RUN    = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRAP   = 3'd0,
      CSR_PCOUNT = 3'd1,
      CSR_SIZE_X = 3'd2,
      CSR_SIZE_Y = 3'd3,
      CSR_SIZE_Z = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_MERGE,
      ST_RD_DATA,
      ST_SEED_RD,
      ST_SEED_WB,
      ST_POP,
      ST_POP_WAIT,
      ST_SRC,
      ST_DIR,
      ST_DST,
      ST_PAT,
      ST_CHK,
      ST_WB
   } state_type;

   typedef struct packed {
      logic              wrap;
      logic [NP_W-1:0]   np;
      logic [EXT_W-1:0]  ext_x;
      logic [EXT_W-1:0]  ext_y;
      logic [EXT_W-1:0]  ext_z;
      logic [DOM_W-1:0]  use_mask;
   } cfg_type;

   typedef struct packed {
      logic clr_write;
      logic latch_req;
      logic compat_wr;
      logic cell_rd_req;
      logic cell_wr_req;
      logic rsp_load_zero;
      logic rsp_load_read;
      logic rsp_load_run;
      logic run_init;
      logic seed_rd;
      logic seed_wb;
      logic pop_rd;
      logic src_rd;
      logic src_ld;
      logic dst_rd;
      logic dst_ld;
      logic pat_rd;
      logic pat_chk;
      logic dst_wb;
      logic dir_next;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic req_inside;
      logic q_empty;
      logic nb_ok;
      logic dir_last;
      logic pat_done;
      logic rsp_free;
   } ctl_status_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] n;
   } nb_type;

   // neighbour coordinate along one axis, source coordinate is inside the extent
   function automatic nb_type nb_axis(input logic [COORD_W-1:0] c,
                                      input logic signed [1:0] delta,
                                      input logic [EXT_W-1:0] s,
                                      input logic wrap);
      nb_type r;
      r.ok = 1'b1;
      r.n  = c;
      if (delta == 2'sd1) begin
         if (EXT_W'(c) + EXT_W'(1) >= s) begin
            r.ok = wrap;
            r.n  = '0;
         end else begin
            r.n = c + COORD_W'(1);
         end
      end else if (delta == -2'sd1) begin
         if (c == '0) begin
            r.ok = wrap;
            r.n  = COORD_W'(s - EXT_W'(1));
         end else begin
            r.n = c - COORD_W'(1);
         end
      end
      return r;
   endfunction

endpackage

[src/tcp_if.sv]
// channel interfaces: command beats, result beats and register writes
`timescale 1ns / 1ps
interface tcp_req_if import tcp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [DIR_W-1:0]     direction;
   logic [PAT_W-1:0]     pattern;
   logic [DOM_W-1:0]     compat_mask;
   logic [COORD_W-1:0]   cell_x;
   logic [COORD_W-1:0]   cell_y;
   logic [COORD_W-1:0]   cell_z;
   logic [DOM_W-1:0]     domain_mask;
   logic                 mark_changed;
   modport source (output valid, cmd, direction, pattern, compat_mask, cell_x, cell_y,
                   cell_z, domain_mask, mark_changed, input ready);
   modport sink (input valid, cmd, direction, pattern, compat_mask, cell_x, cell_y,
                 cell_z, domain_mask, mark_changed, output ready);
endinterface

interface tcp_rsp_if import tcp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DOM_W-1:0]  result_domain;
   logic              contradiction_found;
   modport source (output valid, result_domain, contradiction_found, input ready);
   modport sink (input valid, result_domain, contradiction_found, output ready);
endinterface

interface tcp_csr_if import tcp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/tile_constraint_propagator_3d.sv]
// top level of the 3d tile constraint propagator
`timescale 1ns / 1ps
// usage
//   req_bus carries one command per beat: write compat row, write cell domain,
//   run propagation or read cell. every accepted beat yields exactly one rsp_bus beat.
//   csr_bus writes the five configuration registers; it is always ready and should
//   only be written while no command is in flight.
// command flow
//   compat row write and out-of-grid cell accesses answer in the cycle after the beat.
//   cell read and cell write make one cell memory read, then load the answer;
//   a write does its merge write alongside.
//   a run is data dependent: a seeding sweep over all 512 cells (read, then clear the
//   changed mark and enqueue the marked cells inside the grid), then per worklist entry
//   a pop, a source cell read and, per direction, a neighbour read, one compat row read
//   and check per pattern and a write back; a neighbour off the edge is skipped.
// throughput
//   one command at a time; a new beat is taken once the previous answer is taken,
//   at best every cycle for compat row writes while rsp_bus.ready stays high.
// reset
//   after reset a pass clears every cell, domain and flag bits alike; req_bus.ready
//   stays low until it is done. state, pointer, csr and answer-valid registers reset.
// back pressure
//   the answer waits in an output register while rsp_bus.ready is low; the next
//   command is accepted in the cycle the answer is taken.
module tile_constraint_propagator_3d import tcp_pkg::*; (
   input logic      clock,
   input logic      reset,
   tcp_req_if.sink  req_bus,
   tcp_rsp_if.source rsp_bus,
   tcp_csr_if.sink  csr_bus
);
   cfg_type        cfg;
   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           ready;

   // register file
   tcp_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   // sequencing of commands and of the propagation run
   tcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = ready;

   // memories, worklist pointers and the answer register
   tcp_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .cfg                     (cfg),
      .req_direction           (req_bus.direction),
      .req_pattern             (req_bus.pattern),
      .req_compat_mask         (req_bus.compat_mask),
      .req_cell_x              (req_bus.cell_x),
      .req_cell_y              (req_bus.cell_y),
      .req_cell_z              (req_bus.cell_z),
      .req_domain_mask         (req_bus.domain_mask),
      .req_mark_changed        (req_bus.mark_changed),
      .rsp_valid               (rsp_bus.valid),
      .rsp_ready               (rsp_bus.ready),
      .rsp_result_domain       (rsp_bus.result_domain),
      .rsp_contradiction_found (rsp_bus.contradiction_found)
   );
endmodule

[src/tcp_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[src/tcp_csr.sv]
// configuration registers with clamped views of sizes and pattern count
`timescale 1ns / 1ps
module tcp_csr import tcp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tcp_csr_if.sink   csr,
   output cfg_type   cfg
);
   logic              wrap_ff, wrap_in;
   logic [NP_W-1:0]   pcount_ff, pcount_in;
   logic [EXT_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [NP_W-1:0]   np;

   assign csr.ready = 1'b1;

   always_comb begin
      wrap_in   = wrap_ff;
      pcount_in = pcount_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      sz_in     = sz_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_WRAP:   wrap_in   = csr.data[0];
            CSR_PCOUNT: pcount_in = csr.data[NP_W-1:0];
            CSR_SIZE_X: sx_in     = csr.data[EXT_W-1:0];
            CSR_SIZE_Y: sy_in     = csr.data[EXT_W-1:0];
            CSR_SIZE_Z: sz_in     = csr.data[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff   <= 1'b0;
         pcount_ff <= NP_W'(MAX_PATTERNS);
         sx_ff     <= EXT_W'(MAX_DIM);
         sy_ff     <= EXT_W'(MAX_DIM);
         sz_ff     <= EXT_W'(MAX_DIM);
      end else begin
         wrap_ff   <= wrap_in;
         pcount_ff <= pcount_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         sz_ff     <= sz_in;
      end
   end

   // values above the maximum act as the maximum
   assign np        = (pcount_ff > NP_W'(MAX_PATTERNS)) ? NP_W'(MAX_PATTERNS) : pcount_ff;
   assign cfg.np    = np;
   assign cfg.wrap  = wrap_ff;
   assign cfg.ext_x = (sx_ff > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : sx_ff;
   assign cfg.ext_y = (sy_ff > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : sy_ff;
   assign cfg.ext_z = (sz_ff > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : sz_ff;
   assign cfg.use_mask = DOM_W'(((DOM_W+1)'(1) << np) - (DOM_W+1)'(1));
endmodule

[src/tcp_ctrl.sv]
// control state machine: reset clearing pass, command decode, seeding sweep and worklist drain
`timescale 1ns / 1ps
module tcp_ctrl import tcp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_cmd,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);
   state_type state_ff, state_in;
   cmd_type   op;

   assign op = cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               cmd.latch_req = 1'b1;
               unique case (op)
                  CMD_COMPAT: begin
                     cmd.compat_wr     = 1'b1;
                     cmd.rsp_load_zero = 1'b1;
                  end
                  CMD_WRITE: begin
                     if (status.req_inside) begin
                        cmd.cell_rd_req = 1'b1;
                        state_in        = ST_WR_MERGE;
                     end else begin
                        cmd.rsp_load_zero = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (status.req_inside) begin
                        cmd.cell_rd_req = 1'b1;
                        state_in        = ST_RD_DATA;
                     end else begin
                        cmd.rsp_load_zero = 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = ST_SEED_RD;
                  end
               endcase
            end
         end
         ST_WR_MERGE: begin
            cmd.cell_wr_req   = 1'b1;
            cmd.rsp_load_zero = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_RD_DATA: begin
            cmd.rsp_load_read = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_SEED_RD: begin
            cmd.seed_rd = 1'b1;
            state_in    = ST_SEED_WB;
         end
         ST_SEED_WB: begin
            cmd.seed_wb = 1'b1;
            state_in    = status.sweep_last ? ST_POP : ST_SEED_RD;
         end
         ST_POP: begin
            if (status.q_empty) begin
               cmd.rsp_load_run = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in   = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cmd.src_rd = 1'b1;
            state_in   = ST_SRC;
         end
         ST_SRC: begin
            cmd.src_ld = 1'b1;
            state_in   = ST_DIR;
         end
         ST_DIR: begin
            priority if (status.nb_ok) begin
               cmd.dst_rd = 1'b1;
               state_in   = ST_DST;
            end else if (status.dir_last) begin
               state_in = ST_POP;
            end else begin
               cmd.dir_next = 1'b1;
            end
         end
         ST_DST: begin
            cmd.dst_ld = 1'b1;
            state_in   = ST_PAT;
         end
         ST_PAT: begin
            if (status.pat_done) begin
               state_in = ST_WB;
            end else begin
               cmd.pat_rd = 1'b1;
               state_in   = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.pat_chk = 1'b1;
            state_in    = ST_PAT;
         end
         ST_WB: begin
            cmd.dst_wb = 1'b1;
            if (status.dir_last) begin
               state_in = ST_POP;
            end else begin
               cmd.dir_next = 1'b1;
               state_in     = ST_DIR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

[src/tcp_datapath.sv]
// datapath: cell, worklist and compat memories, counters and result register
`timescale 1ns / 1ps
module tcp_datapath import tcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output ctl_status_type     status,
   input  cfg_type            cfg,
   input  logic [DIR_W-1:0]   req_direction,
   input  logic [PAT_W-1:0]   req_pattern,
   input  logic [DOM_W-1:0]   req_compat_mask,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic [COORD_W-1:0] req_cell_z,
   input  logic [DOM_W-1:0]   req_domain_mask,
   input  logic               req_mark_changed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DOM_W-1:0]   rsp_result_domain,
   output logic               rsp_contradiction_found
);
   logic [CELL_AW-1:0] req_idx_ff, req_idx_in;
   logic [DOM_W-1:0]   wr_dom_ff, wr_dom_in;
   logic               mark_ff, mark_in;
   logic [CELL_AW-1:0] sweep_ff, sweep_in;
   logic [CELL_AW-1:0] head_ff, head_in;
   logic [QLEN_W-1:0]  len_ff, len_in;
   logic [CELL_AW-1:0] src_idx_ff, src_idx_in;
   logic [DOM_W-1:0]   src_dom_ff, src_dom_in;
   logic [CELL_AW-1:0] dst_idx_ff, dst_idx_in;
   logic [DOM_W-1:0]   dst_dom_ff, dst_dom_in;
   logic               dst_q_ff, dst_q_in;
   logic               changed_ff, changed_in;
   logic               contra_ff, contra_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [NP_W-1:0]    pat_ff, pat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DOM_W-1:0]   rsp_dom_ff, rsp_dom_in;
   logic               rsp_contra_ff, rsp_contra_in;

   logic [CELL_AW-1:0] req_idx_live, nb_idx, tail;
   logic               cell_we, cell_re, q_we, compat_we;
   logic [CELL_AW-1:0] cell_waddr, cell_raddr;
   logic [CELL_W-1:0]  cell_wdata, cell_rdata;
   logic [CELL_AW-1:0] q_wdata, q_rdata;
   logic [DOM_W-1:0]   compat_rdata, src_eff;
   logic               sweep_inside, seed_enq, dst_enq;
   nb_type             nb_x, nb_y, nb_z;

   assign req_idx_live = {req_cell_x, req_cell_y, req_cell_z};
   assign tail = head_ff + len_ff[CELL_AW-1:0];

   function automatic logic in_grid(input logic [CELL_AW-1:0] idx, input cfg_type c);
      return EXT_W'(idx[3*COORD_W-1:2*COORD_W]) < c.ext_x &&
             EXT_W'(idx[2*COORD_W-1:COORD_W]) < c.ext_y &&
             EXT_W'(idx[COORD_W-1:0]) < c.ext_z;
   endfunction

   assign sweep_inside = in_grid(sweep_ff, cfg);
   assign seed_enq     = cell_rdata[CHANGED_BIT] && sweep_inside;
   assign dst_enq      = changed_ff && !dst_q_ff;

   // neighbour of the source cell in the current direction
   assign nb_x = nb_axis(src_idx_ff[3*COORD_W-1:2*COORD_W], STEP_X[dir_ff], cfg.ext_x, cfg.wrap);
   assign nb_y = nb_axis(src_idx_ff[2*COORD_W-1:COORD_W], STEP_Y[dir_ff], cfg.ext_y, cfg.wrap);
   assign nb_z = nb_axis(src_idx_ff[COORD_W-1:0], STEP_Z[dir_ff], cfg.ext_z, cfg.wrap);
   assign nb_idx = {nb_x.n, nb_y.n, nb_z.n};

   // a cell that is its own neighbour sees its removals at once
   assign src_eff = (dst_idx_ff == src_idx_ff) ? dst_dom_ff : src_dom_ff;

   always_comb begin
      cell_re    = 1'b1;
      cell_raddr = nb_idx;
      priority if (cmd.cell_rd_req) begin
         cell_raddr = req_idx_live;
      end else if (cmd.seed_rd) begin
         cell_raddr = sweep_ff;
      end else if (cmd.src_rd) begin
         cell_raddr = q_rdata;
      end else if (cmd.dst_rd) begin
         cell_raddr = nb_idx;
      end else begin
         cell_re = 1'b0;
      end
   end

   always_comb begin
      cell_we    = 1'b1;
      cell_waddr = sweep_ff;
      cell_wdata = '0;
      priority if (cmd.clr_write) begin
         cell_wdata = '0;
      end else if (cmd.cell_wr_req) begin
         cell_waddr = req_idx_ff;
         cell_wdata = {cell_rdata[CHANGED_BIT] | mark_ff, cell_rdata[QUEUED_BIT], wr_dom_ff};
      end else if (cmd.seed_wb) begin
         cell_wdata = {1'b0, seed_enq, cell_rdata[DOM_W-1:0]};
      end else if (cmd.src_ld) begin
         cell_waddr = src_idx_ff;
         cell_wdata = {2'b00, cell_rdata[DOM_W-1:0]};
      end else if (cmd.dst_wb) begin
         cell_waddr = dst_idx_ff;
         cell_wdata = {1'b0, dst_q_ff | changed_ff, dst_dom_ff};
      end else begin
         cell_we = 1'b0;
      end
   end

   assign q_we      = (cmd.seed_wb && seed_enq) || (cmd.dst_wb && dst_enq);
   assign q_wdata   = cmd.seed_wb ? sweep_ff : dst_idx_ff;
   assign compat_we = cmd.compat_wr && (req_direction < DIR_W'(DIRECTIONS));

   tcp_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_en   (cell_re),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   tcp_ram #(.WIDTH(CELL_AW), .DEPTH(CELL_COUNT)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail),
      .wr_data (q_wdata),
      .rd_en   (cmd.pop_rd),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   tcp_ram #(.WIDTH(DOM_W), .DEPTH(COMPAT_DEPTH)) u_compat_ram (
      .clock   (clock),
      .wr_en   (compat_we),
      .wr_addr ({req_direction, req_pattern}),
      .wr_data (req_compat_mask),
      .rd_en   (cmd.pat_rd),
      .rd_addr ({dir_ff, pat_ff[PAT_W-1:0]}),
      .rd_data (compat_rdata)
   );

   always_comb begin
      req_idx_in    = req_idx_ff;
      wr_dom_in     = wr_dom_ff;
      mark_in       = mark_ff;
      sweep_in      = sweep_ff;
      head_in       = head_ff;
      len_in        = len_ff;
      src_idx_in    = src_idx_ff;
      src_dom_in    = src_dom_ff;
      dst_idx_in    = dst_idx_ff;
      dst_dom_in    = dst_dom_ff;
      dst_q_in      = dst_q_ff;
      changed_in    = changed_ff;
      contra_in     = contra_ff;
      dir_in        = dir_ff;
      pat_in        = pat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dom_in    = rsp_dom_ff;
      rsp_contra_in = rsp_contra_ff;

      if (cmd.latch_req) begin
         req_idx_in = req_idx_live;
         wr_dom_in  = req_domain_mask;
         mark_in    = req_mark_changed;
      end
      if (cmd.run_init) begin
         sweep_in  = '0;
         contra_in = 1'b0;
      end
      if (cmd.clr_write || cmd.seed_wb) sweep_in = sweep_ff + CELL_AW'(1);
      if (q_we) len_in = len_ff + QLEN_W'(1);
      if (cmd.src_rd) src_idx_in = q_rdata;
      if (cmd.src_ld) begin
         src_dom_in = cell_rdata[DOM_W-1:0];
         head_in    = head_ff + CELL_AW'(1);
         len_in     = len_ff - QLEN_W'(1);
         dir_in     = '0;
      end
      if (cmd.dir_next) dir_in = dir_ff + DIR_W'(1);
      if (cmd.dst_rd) dst_idx_in = nb_idx;
      if (cmd.dst_ld) begin
         dst_dom_in = cell_rdata[DOM_W-1:0];
         dst_q_in   = cell_rdata[QUEUED_BIT];
         changed_in = 1'b0;
         pat_in     = '0;
      end
      if (cmd.pat_chk) begin
         pat_in = pat_ff + NP_W'(1);
         if (dst_dom_ff[pat_ff[PAT_W-1:0]] &&
             ((compat_rdata & src_eff & cfg.use_mask) == '0)) begin
            dst_dom_in[pat_ff[PAT_W-1:0]] = 1'b0;
            changed_in = 1'b1;
         end
      end
      if (cmd.dst_wb) begin
         if (changed_ff && ((dst_dom_ff & cfg.use_mask) == '0)) contra_in = 1'b1;
         if (dst_idx_ff == src_idx_ff) src_dom_in = dst_dom_ff;
      end
      if (cmd.rsp_load_zero || cmd.rsp_load_read || cmd.rsp_load_run) begin
         rsp_valid_in  = 1'b1;
         rsp_dom_in    = cmd.rsp_load_read ? cell_rdata[DOM_W-1:0] : '0;
         rsp_contra_in = cmd.rsp_load_run ? contra_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         head_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_idx_ff    <= req_idx_in;
      wr_dom_ff     <= wr_dom_in;
      mark_ff       <= mark_in;
      src_idx_ff    <= src_idx_in;
      src_dom_ff    <= src_dom_in;
      dst_idx_ff    <= dst_idx_in;
      dst_dom_ff    <= dst_dom_in;
      dst_q_ff      <= dst_q_in;
      changed_ff    <= changed_in;
      contra_ff     <= contra_in;
      dir_ff        <= dir_in;
      pat_ff        <= pat_in;
      rsp_dom_ff    <= rsp_dom_in;
      rsp_contra_ff <= rsp_contra_in;
   end

   assign status.sweep_last = &sweep_ff;
   assign status.req_inside = in_grid(req_idx_live, cfg);
   assign status.q_empty    = (len_ff == '0);
   assign status.nb_ok      = nb_x.ok && nb_y.ok && nb_z.ok;
   assign status.dir_last   = (dir_ff == DIR_W'(DIRECTIONS - 1));
   assign status.pat_done   = (pat_ff == cfg.np);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_domain       = rsp_dom_ff;
   assign rsp_contradiction_found = rsp_contra_ff;
endmodule

[src/tcp_checker.sv]
// port-level checks of the propagator, bound to the top level
`timescale 1ns / 1ps
module tcp_checker import tcp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DOM_W-1:0] rsp_result_domain,
   input logic             rsp_contradiction_found
);
   logic [1:0] open_ff, open_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_beat && !rsp_beat) open_in = open_ff + 2'd1;
      if (!req_beat && rsp_beat) open_in = open_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("ready during clearing pass");

   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("answer without a command");

   a_one_open: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> (open_ff == 2'd0 || rsp_beat))
      else $error("second command taken before answer");

   a_run_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contradiction_found |-> rsp_result_domain == '0)
      else $error("run answer carries a domain");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_domain)
         && $stable(rsp_contradiction_found))
      else $error("stalled answer changed");
endmodule

bind tile_constraint_propagator_3d tcp_checker u_tcp_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_bus.valid),
   .req_ready               (req_bus.ready),
   .rsp_valid               (rsp_bus.valid),
   .rsp_ready               (rsp_bus.ready),
   .rsp_result_domain       (rsp_bus.result_domain),
   .rsp_contradiction_found (rsp_bus.contradiction_found)
);
